// File: rtl/mwmu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mwmu_pkg
// Request, direction, map select and register index codes of the maze
// wall map update block.
// ----------------------------------------------------------------------------
package mwmu_pkg;

  // Request codes.
  typedef logic [1:0] req_t;
  localparam req_t REQ_SENSE  = 2'd0;
  localparam req_t REQ_QUERY  = 2'd1;
  localparam req_t REQ_REINIT = 2'd2;

  // Wall sides and headings. Left is heading plus one, right is heading plus three.
  typedef logic [1:0] dir_t;
  localparam dir_t DIR_N = 2'd0;
  localparam dir_t DIR_W = 2'd1;
  localparam dir_t DIR_S = 2'd2;
  localparam dir_t DIR_E = 2'd3;
  localparam dir_t TURN_LEFT  = 2'd1;
  localparam dir_t TURN_RIGHT = 2'd3;

  // Map selection for queries.
  typedef logic [1:0] map_sel_t;
  localparam map_sel_t MAP_SEEN    = 2'd0;
  localparam map_sel_t MAP_CHECKED = 2'd1;
  localparam map_sel_t MAP_PESS    = 2'd2;

  // Configuration register indexes.
  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_MAPPING_ENABLE  = 2'd0;
  localparam cfg_idx_t CFG_FRONT_THRESHOLD = 2'd1;
  localparam cfg_idx_t CFG_RIGHT_THRESHOLD = 2'd2;
  localparam cfg_idx_t CFG_LEFT_THRESHOLD  = 2'd3;

  // Sensor side slots used by the update logic.
  localparam int SIDE_FRONT = 0;
  localparam int SIDE_RIGHT = 1;
  localparam int SIDE_LEFT  = 2;
  localparam int SIDES      = 3;

endpackage
`default_nettype wire

// File: rtl/maze_wall_map_update.sv
`default_nettype none
// ----------------------------------------------------------------------------
// maze_wall_map_update
// Keeps the seen, checked and pessimistic wall maps of a square maze,
// applies sensor updates, answers wall queries and restores boot patterns.
// ----------------------------------------------------------------------------
// A taken start passes the input and result registers before out_valid.
// Throughput: one item per cycle; busy is always low. The cycle is set by the
// wall flip-flops, each of which decodes its own update in the result stage.
// The receiver cannot stall; every result is shown for one cycle only.
// Reset (rst_n low, synchronous) restores the boot maps and the register
// defaults and drops any item in flight.
module maze_wall_map_update
  import mwmu_pkg::*;
#(
  parameter int MAZE_SIZE   = 16,
  parameter int SENSOR_BITS = 12
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // Input channel
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [1:0]                  in_req_type,
  input  wire logic [$clog2(MAZE_SIZE)-1:0] in_cell_x,
  input  wire logic [$clog2(MAZE_SIZE)-1:0] in_cell_y,
  input  wire logic [1:0]                  in_heading,
  input  wire logic [1:0]                  in_map_select,
  input  wire logic [SENSOR_BITS-1:0]      in_front_level,
  input  wire logic [SENSOR_BITS-1:0]      in_right_level,
  input  wire logic [SENSOR_BITS-1:0]      in_left_level,
  // Configuration port
  input  wire logic                        cfg_we,
  input  wire logic [1:0]                  cfg_index,
  input  wire logic [SENSOR_BITS-1:0]      cfg_wdata,
  // Result channel
  output logic                             out_valid,
  output logic                             out_wall_present,
  output logic                             out_front_seen,
  output logic                             out_right_seen,
  output logic                             out_left_seen
);

  localparam int CW    = $clog2(MAZE_SIZE);
  localparam int WORDS = MAZE_SIZE + 1;
  localparam int WW    = $clog2(WORDS);

  localparam logic [CW:0]          SIZE_V    = (CW + 1)'(MAZE_SIZE);
  localparam logic [MAZE_SIZE-1:0] ALL_ONES  = {MAZE_SIZE{1'b1}};
  localparam logic [MAZE_SIZE-1:0] LOW_ONE   = MAZE_SIZE'(1);
  localparam logic [SENSOR_BITS-1:0] THR_RESET = SENSOR_BITS'(32'd2048);

  // Location of one wall: column or row word and the bit in it.
  typedef struct packed {
    logic          ok;
    logic          is_col;
    logic [WW-1:0] word;
    logic [CW-1:0] bpos;
  } loc_t;

  function automatic loc_t locate(logic [CW-1:0] x, logic [CW-1:0] y, dir_t dir);
    loc_t l;
    l.ok     = ({1'b0, x} < SIZE_V) && ({1'b0, y} < SIZE_V);
    l.is_col = 1'b0;
    l.word   = WW'(y);
    l.bpos   = x;
    case (dir)
      DIR_N: begin
        l.is_col = 1'b0;
        l.word   = WW'(y) + WW'(1);
        l.bpos   = x;
      end
      DIR_W: begin
        l.is_col = 1'b1;
        l.word   = WW'(x);
        l.bpos   = y;
      end
      DIR_S: begin
        l.is_col = 1'b0;
        l.word   = WW'(y);
        l.bpos   = x;
      end
      DIR_E: begin
        l.is_col = 1'b1;
        l.word   = WW'(x) + WW'(1);
        l.bpos   = y;
      end
      default: begin
        l.ok = 1'b0;
      end
    endcase
    return l;
  endfunction

  // Boot pattern of the seen and checked column words.
  function automatic logic [MAZE_SIZE-1:0] boot_plain_col(int c);
    logic [MAZE_SIZE-1:0] v;
    v = '0;
    if (c == 0 || c == MAZE_SIZE) begin
      v = ALL_ONES;
    end else if (c == 1) begin
      v = LOW_ONE;
    end
    return v;
  endfunction

  // Boot pattern of the seen and checked row words.
  function automatic logic [MAZE_SIZE-1:0] boot_plain_row(int r);
    logic [MAZE_SIZE-1:0] v;
    v = '0;
    if (r == 0 || r == MAZE_SIZE) begin
      v = ALL_ONES;
    end
    return v;
  endfunction

  // Boot pattern of the pessimistic row words: the start cell has no north wall.
  function automatic logic [MAZE_SIZE-1:0] boot_pess_row(int r);
    logic [MAZE_SIZE-1:0] v;
    v = ALL_ONES;
    if (r == 1) begin
      v = ALL_ONES & ~LOW_ONE;
    end
    return v;
  endfunction

  // Configuration registers.
  logic                   map_en_r;
  logic [SENSOR_BITS-1:0] front_thr_r;
  logic [SENSOR_BITS-1:0] right_thr_r;
  logic [SENSOR_BITS-1:0] left_thr_r;

  // Input register stage.
  logic                   s1_valid_r;
  req_t                   s1_req_r;
  logic [CW-1:0]          s1_x_r;
  logic [CW-1:0]          s1_y_r;
  dir_t                   s1_hd_r;
  map_sel_t               s1_sel_r;
  logic [SENSOR_BITS-1:0] s1_front_r;
  logic [SENSOR_BITS-1:0] s1_right_r;
  logic [SENSOR_BITS-1:0] s1_left_r;

  // Wall maps, one flip-flop per wall.
  logic [MAZE_SIZE-1:0] seen_col_r [WORDS];
  logic [MAZE_SIZE-1:0] seen_row_r [WORDS];
  logic [MAZE_SIZE-1:0] chk_col_r  [WORDS];
  logic [MAZE_SIZE-1:0] chk_row_r  [WORDS];
  logic [MAZE_SIZE-1:0] pess_col_r [WORDS];
  logic [MAZE_SIZE-1:0] pess_row_r [WORDS];
  logic [MAZE_SIZE-1:0] seen_col_nxt [WORDS];
  logic [MAZE_SIZE-1:0] seen_row_nxt [WORDS];
  logic [MAZE_SIZE-1:0] chk_col_nxt  [WORDS];
  logic [MAZE_SIZE-1:0] chk_row_nxt  [WORDS];
  logic [MAZE_SIZE-1:0] pess_col_nxt [WORDS];
  logic [MAZE_SIZE-1:0] pess_row_nxt [WORDS];

  // Result register.
  logic out_valid_r;
  logic out_wall_r;
  logic out_front_r;
  logic out_right_r;
  logic out_left_r;

  logic wall_nxt;
  logic front_hit;
  logic right_hit;
  logic left_hit;
  logic do_sense;
  logic do_update;
  logic do_reinit;
  loc_t qloc;
  loc_t side_loc [SIDES];
  logic side_hit [SIDES];
  logic rd_seen;
  logic rd_chk;
  logic rd_pess;

  // An item can enter every cycle.
  assign busy = 1'b0;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_en_r    <= 1'b1;
      front_thr_r <= THR_RESET;
      right_thr_r <= THR_RESET;
      left_thr_r  <= THR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAPPING_ENABLE:  map_en_r    <= cfg_wdata[0];
        CFG_FRONT_THRESHOLD: front_thr_r <= cfg_wdata;
        CFG_RIGHT_THRESHOLD: right_thr_r <= cfg_wdata;
        CFG_LEFT_THRESHOLD:  left_thr_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register: capture each transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      s1_req_r   <= in_req_type;
      s1_x_r     <= in_cell_x;
      s1_y_r     <= in_cell_y;
      s1_hd_r    <= in_heading;
      s1_sel_r   <= in_map_select;
      s1_front_r <= in_front_level;
      s1_right_r <= in_right_level;
      s1_left_r  <= in_left_level;
    end
  end

  // Sensor decisions and request decode.
  assign front_hit = s1_front_r > front_thr_r;
  assign right_hit = s1_right_r > right_thr_r;
  assign left_hit  = s1_left_r > left_thr_r;
  assign do_sense  = s1_valid_r && (s1_req_r == REQ_SENSE);
  assign do_update = do_sense && map_en_r;
  assign do_reinit = s1_valid_r && (s1_req_r == REQ_REINIT);

  // Walls in front, to the right and to the left of the robot.
  always_comb begin
    side_loc[SIDE_FRONT] = locate(s1_x_r, s1_y_r, s1_hd_r);
    side_loc[SIDE_RIGHT] = locate(s1_x_r, s1_y_r, s1_hd_r + TURN_RIGHT);
    side_loc[SIDE_LEFT]  = locate(s1_x_r, s1_y_r, s1_hd_r + TURN_LEFT);
    side_hit[SIDE_FRONT] = front_hit;
    side_hit[SIDE_RIGHT] = right_hit;
    side_hit[SIDE_LEFT]  = left_hit;
  end

  // Next map contents. The three sides are always different walls, so each
  // one is judged against the seen map as it stood before this update.
  always_comb begin
    logic [MAZE_SIZE-1:0] onehot;
    logic [MAZE_SIZE-1:0] cmask;
    logic [MAZE_SIZE-1:0] rmask;
    for (int c = 0; c < WORDS; c++) begin
      seen_col_nxt[c] = seen_col_r[c];
      seen_row_nxt[c] = seen_row_r[c];
      chk_col_nxt[c]  = chk_col_r[c];
      chk_row_nxt[c]  = chk_row_r[c];
      pess_col_nxt[c] = pess_col_r[c];
      pess_row_nxt[c] = pess_row_r[c];
      for (int s = 0; s < SIDES; s++) begin
        onehot = LOW_ONE << side_loc[s].bpos;
        cmask  = (do_update && side_loc[s].ok && side_loc[s].is_col &&
                  side_loc[s].word == WW'(c)) ? onehot : '0;
        rmask  = (do_update && side_loc[s].ok && !side_loc[s].is_col &&
                  side_loc[s].word == WW'(c)) ? onehot : '0;
        chk_col_nxt[c] = chk_col_nxt[c] | cmask;
        chk_row_nxt[c] = chk_row_nxt[c] | rmask;
        if (side_hit[s]) begin
          seen_col_nxt[c] = seen_col_nxt[c] | cmask;
          seen_row_nxt[c] = seen_row_nxt[c] | rmask;
        end else begin
          pess_col_nxt[c] = pess_col_nxt[c] & ~(cmask & ~seen_col_r[c]);
          pess_row_nxt[c] = pess_row_nxt[c] & ~(rmask & ~seen_row_r[c]);
        end
      end
      if (do_reinit) begin
        seen_col_nxt[c] = boot_plain_col(c);
        seen_row_nxt[c] = boot_plain_row(c);
        chk_col_nxt[c]  = boot_plain_col(c);
        chk_row_nxt[c]  = boot_plain_row(c);
        pess_col_nxt[c] = ALL_ONES;
        pess_row_nxt[c] = boot_pess_row(c);
      end
    end
  end

  // Map registers; reset loads the boot patterns.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < WORDS; c++) begin
        seen_col_r[c] <= boot_plain_col(c);
        seen_row_r[c] <= boot_plain_row(c);
        chk_col_r[c]  <= boot_plain_col(c);
        chk_row_r[c]  <= boot_plain_row(c);
        pess_col_r[c] <= ALL_ONES;
        pess_row_r[c] <= boot_pess_row(c);
      end
    end else begin
      for (int c = 0; c < WORDS; c++) begin
        seen_col_r[c] <= seen_col_nxt[c];
        seen_row_r[c] <= seen_row_nxt[c];
        chk_col_r[c]  <= chk_col_nxt[c];
        chk_row_r[c]  <= chk_row_nxt[c];
        pess_col_r[c] <= pess_col_nxt[c];
        pess_row_r[c] <= pess_row_nxt[c];
      end
    end
  end

  // Query read of one wall bit; a cell outside the maze reads as open.
  always_comb begin
    qloc    = locate(s1_x_r, s1_y_r, s1_hd_r);
    rd_seen = 1'b0;
    rd_chk  = 1'b0;
    rd_pess = 1'b0;
    if (qloc.ok) begin
      if (qloc.is_col) begin
        rd_seen = seen_col_r[qloc.word][qloc.bpos];
        rd_chk  = chk_col_r[qloc.word][qloc.bpos];
        rd_pess = pess_col_r[qloc.word][qloc.bpos];
      end else begin
        rd_seen = seen_row_r[qloc.word][qloc.bpos];
        rd_chk  = chk_row_r[qloc.word][qloc.bpos];
        rd_pess = pess_row_r[qloc.word][qloc.bpos];
      end
    end
    case (s1_sel_r)
      MAP_SEEN:    wall_nxt = rd_seen;
      MAP_CHECKED: wall_nxt = rd_chk;
      MAP_PESS:    wall_nxt = rd_pess;
      default:     wall_nxt = 1'b0;
    endcase
  end

  // Result register: one strobe per transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    out_wall_r  <= s1_valid_r && (s1_req_r == REQ_QUERY) && wall_nxt;
    out_front_r <= do_sense && front_hit;
    out_right_r <= do_sense && right_hit;
    out_left_r  <= do_sense && left_hit;
  end

  assign out_valid        = out_valid_r;
  assign out_wall_present = out_wall_r;
  assign out_front_seen   = out_front_r;
  assign out_right_seen   = out_right_r;
  assign out_left_seen    = out_left_r;

endmodule
`default_nettype wire

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for maze_wall_map_update. A driver pulls requests
// from a queue and predicts the three wall maps. A monitor compares every
// result strobe with the oldest prediction. The run steps through several
// threshold and mapping settings, with directed checks at the start.
// ----------------------------------------------------------------------------
module tb;
  import mwmu_pkg::*;

  localparam int     PHASES          = 10;
  localparam int     ITEMS_PER_PHASE = 95;
  localparam int     STALL_LIMIT     = 2000;
  localparam req_t     REQ_UNUSED = 2'd3;
  localparam map_sel_t MAP_UNUSED = 2'd3;

  typedef struct packed {
    req_t        req;
    logic [3:0]  x;
    logic [3:0]  y;
    dir_t        heading;
    map_sel_t    sel;
    logic [11:0] front;
    logic [11:0] right;
    logic [11:0] left;
  } map_request_t;

  typedef struct packed {
    logic wall_present;
    logic front_seen;
    logic right_seen;
    logic left_seen;
  } wall_result_t;

  logic        clk              = 1'b0;
  logic        rst_n            = 1'b0;
  logic        start            = 1'b0;
  logic        busy;
  logic [1:0]  in_req_type      = '0;
  logic [3:0]  in_cell_x        = '0;
  logic [3:0]  in_cell_y        = '0;
  logic [1:0]  in_heading       = '0;
  logic [1:0]  in_map_select    = '0;
  logic [11:0] in_front_level   = '0;
  logic [11:0] in_right_level   = '0;
  logic [11:0] in_left_level    = '0;
  logic        cfg_we           = 1'b0;
  logic [1:0]  cfg_index        = '0;
  logic [11:0] cfg_wdata        = '0;
  logic        out_valid;
  logic        out_wall_present;
  logic        out_front_seen;
  logic        out_right_seen;
  logic        out_left_seen;

  maze_wall_map_update uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_req_type      (in_req_type),
    .in_cell_x        (in_cell_x),
    .in_cell_y        (in_cell_y),
    .in_heading       (in_heading),
    .in_map_select    (in_map_select),
    .in_front_level   (in_front_level),
    .in_right_level   (in_right_level),
    .in_left_level    (in_left_level),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .out_valid        (out_valid),
    .out_wall_present (out_wall_present),
    .out_front_seen   (out_front_seen),
    .out_right_seen   (out_right_seen),
    .out_left_seen    (out_left_seen)
  );

  always #6 clk = ~clk;

  // Predicted maps, indexed by the map select code.
  logic [15:0] wall_cols [3][17];
  logic [15:0] wall_rows [3][17];

  // Shadow copies of the configuration registers.
  logic        mapping_on;
  logic [11:0] front_limit;
  logic [11:0] right_limit;
  logic [11:0] left_limit;

  map_request_t pending_requests [$];
  wall_result_t expected_results [$];
  map_request_t drive_item   = '0;
  int           gap_left     = 0;
  bit           idle_on      = 1'b1;
  int           error_count  = 0;
  int           result_count = 0;
  int           stall_cycles = 0;
  logic [3:0]   walk_x       = '0;
  logic [3:0]   walk_y       = '0;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    error_count++;
  endtask

  // Boot patterns: plain maps hold only the outer walls and the start cell's
  // east wall, the pessimistic map holds every wall but the start cell's north.
  function automatic void boot_walls();
    for (int m = 0; m < 3; m++) begin
      for (int i = 0; i < 17; i++) begin
        if (m == MAP_PESS) begin
          wall_cols[m][i] = 16'hffff;
          wall_rows[m][i] = 16'hffff;
        end else begin
          wall_cols[m][i] = (i == 0 || i == 16) ? 16'hffff : 16'h0000;
          wall_rows[m][i] = (i == 0 || i == 16) ? 16'hffff : 16'h0000;
        end
      end
      if (m == MAP_PESS) wall_rows[m][1] = 16'hfffe;
      else wall_cols[m][1] = 16'h0001;
    end
  endfunction

  // A 4-bit coordinate always lies inside the 16x16 maze.
  function automatic logic read_wall(int m, logic [3:0] x, logic [3:0] y, dir_t d);
    logic w;
    case (d)
      DIR_N:   w = wall_rows[m][int'(y) + 1][x];
      DIR_W:   w = wall_cols[m][x][y];
      DIR_S:   w = wall_rows[m][y][x];
      default: w = wall_cols[m][int'(x) + 1][y];
    endcase
    return w;
  endfunction

  function automatic void write_wall(int m, logic [3:0] x, logic [3:0] y, dir_t d, logic v);
    case (d)
      DIR_N:   wall_rows[m][int'(y) + 1][x] = v;
      DIR_W:   wall_cols[m][x][y] = v;
      DIR_S:   wall_rows[m][y][x] = v;
      default: wall_cols[m][int'(x) + 1][y] = v;
    endcase
  endfunction

  // A strong reading marks the wall seen; a weak one opens it in the
  // pessimistic map unless the wall was seen before.
  function automatic void sense_wall(logic hit, logic [3:0] x, logic [3:0] y, dir_t d);
    if (hit) write_wall(MAP_SEEN, x, y, d, 1'b1);
    else if (!read_wall(MAP_SEEN, x, y, d)) write_wall(MAP_PESS, x, y, d, 1'b0);
  endfunction

  function automatic wall_result_t predict_wall_result(map_request_t r);
    wall_result_t res;
    dir_t         lside;
    dir_t         rside;
    res = '0;
    case (r.req)
      REQ_SENSE: begin
        res.front_seen = r.front > front_limit;
        res.right_seen = r.right > right_limit;
        res.left_seen  = r.left > left_limit;
        if (mapping_on) begin
          lside = r.heading + TURN_LEFT;
          rside = r.heading + TURN_RIGHT;
          write_wall(MAP_CHECKED, r.x, r.y, r.heading, 1'b1);
          write_wall(MAP_CHECKED, r.x, r.y, lside, 1'b1);
          write_wall(MAP_CHECKED, r.x, r.y, rside, 1'b1);
          sense_wall(res.front_seen, r.x, r.y, r.heading);
          sense_wall(res.right_seen, r.x, r.y, rside);
          sense_wall(res.left_seen, r.x, r.y, lside);
        end
      end
      REQ_QUERY: begin
        if (r.sel != MAP_UNUSED) res.wall_present = read_wall(r.sel, r.x, r.y, r.heading);
      end
      REQ_REINIT: boot_walls();
      default: ;
    endcase
    return res;
  endfunction

  function automatic map_request_t make_request(req_t req, logic [3:0] x, logic [3:0] y,
                                                dir_t hd, map_sel_t sel, logic [11:0] f,
                                                logic [11:0] r, logic [11:0] l);
    map_request_t item;
    item = '{req, x, y, hd, sel, f, r, l};
    return item;
  endfunction

  // Sensor level: extremes, values around the threshold, or anything.
  function automatic logic [11:0] draw_level(logic [11:0] limit);
    int v;
    case ($urandom_range(0, 7))
      0:       v = 0;
      1:       v = 4095;
      2, 3:    v = int'(limit) + int'($urandom_range(0, 4)) - 2;
      default: v = $urandom_range(0, 4095);
    endcase
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[11:0];
  endfunction

  // Mostly a robot walking through neighboring cells, so that queries land on
  // walls that earlier updates touched; a little noise and a rare reinit.
  function automatic map_request_t draw_request();
    map_request_t item;
    int           kind;
    kind = $urandom_range(0, 99);
    if ($urandom_range(0, 3) != 0) begin
      walk_x = walk_x + 4'($urandom_range(0, 2)) - 4'd1;
      walk_y = walk_y + 4'($urandom_range(0, 2)) - 4'd1;
    end else begin
      walk_x = 4'($urandom_range(0, 15));
      walk_y = 4'($urandom_range(0, 15));
    end
    item.x       = walk_x;
    item.y       = walk_y;
    item.heading = dir_t'($urandom_range(0, 3));
    item.sel     = ($urandom_range(0, 9) == 0) ? MAP_UNUSED : map_sel_t'($urandom_range(0, 2));
    item.front   = draw_level(front_limit);
    item.right   = draw_level(right_limit);
    item.left    = draw_level(left_limit);
    if (kind < 55) item.req = REQ_SENSE;
    else if (kind < 95) item.req = REQ_QUERY;
    else if (kind < 98) item.req = REQ_UNUSED;
    else item.req = REQ_REINIT;
    return item;
  endfunction

  function automatic int draw_gap();
    int k;
    if (!idle_on) return 0;
    k = $urandom_range(0, 99);
    if (k < 60) return 0;
    if (k < 90) return $urandom_range(1, 3);
    if (k < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Driver: a request transfers when start is high and busy is low.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_results.push_back(predict_wall_result(drive_item));
        gap_left = draw_gap();
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          drive_item = pending_requests.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
      in_req_type    <= drive_item.req;
      in_cell_x      <= drive_item.x;
      in_cell_y      <= drive_item.y;
      in_heading     <= drive_item.heading;
      in_map_select  <= drive_item.sel;
      in_front_level <= drive_item.front;
      in_right_level <= drive_item.right;
      in_left_level  <= drive_item.left;
    end
  end

  // Monitor: every strobe is one result transfer.
  always @(posedge clk) begin
    wall_result_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result strobe with no request outstanding");
      end else begin
        want = expected_results.pop_front();
        if (out_wall_present !== want.wall_present)
          report_mismatch($sformatf("result %0d wall_present got %b want %b",
                                    result_count, out_wall_present, want.wall_present));
        if (out_front_seen !== want.front_seen)
          report_mismatch($sformatf("result %0d front_seen got %b want %b",
                                    result_count, out_front_seen, want.front_seen));
        if (out_right_seen !== want.right_seen)
          report_mismatch($sformatf("result %0d right_seen got %b want %b",
                                    result_count, out_right_seen, want.right_seen));
        if (out_left_seen !== want.left_seen)
          report_mismatch($sformatf("result %0d left_seen got %b want %b",
                                    result_count, out_left_seen, want.left_seen));
      end
      result_count++;
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid === 1'b1) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [11:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      CFG_MAPPING_ENABLE:  mapping_on  = value[0];
      CFG_FRONT_THRESHOLD: front_limit = value;
      CFG_RIGHT_THRESHOLD: right_limit = value;
      default:             left_limit  = value;
    endcase
  endtask

  // Sets all registers for one phase; the enable carries junk in its upper bits.
  task automatic configure_phase(int p);
    logic        en;
    logic [11:0] thr [3];
    en = ($urandom_range(0, 3) != 0);
    for (int i = 0; i < 3; i++) thr[i] = 12'($urandom_range(0, 4095));
    case (p)
      1: begin
        en = 1'b1;
        for (int i = 0; i < 3; i++) thr[i] = 12'd0;
      end
      2: for (int i = 0; i < 3; i++) thr[i] = 12'd4095;
      3: en = 1'b0;
      default: ;
    endcase
    write_reg(CFG_MAPPING_ENABLE, {11'($urandom_range(0, 2047)), en});
    write_reg(CFG_FRONT_THRESHOLD, thr[0]);
    write_reg(CFG_RIGHT_THRESHOLD, thr[1]);
    write_reg(CFG_LEFT_THRESHOLD, thr[2]);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Holds the sender until every expected result has arrived.
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_requests.size() != 0 || start || expected_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Directed checks at the reset settings: boot patterns, threshold edges,
  // every heading, unused codes and a reinit that undoes the updates.
  task automatic load_boot_checks();
    pending_requests.push_back(make_request(REQ_QUERY, 0, 0, DIR_S, MAP_SEEN, 0, 0, 0));
    pending_requests.push_back(make_request(REQ_QUERY, 0, 0, DIR_N, MAP_PESS, 0, 0, 0));
    pending_requests.push_back(make_request(REQ_QUERY, 0, 0, DIR_E, MAP_CHECKED, 0, 0, 0));
    pending_requests.push_back(make_request(REQ_QUERY, 15, 15, DIR_E, MAP_SEEN, 0, 0, 0));
    pending_requests.push_back(make_request(REQ_QUERY, 15, 15, DIR_N, MAP_UNUSED,
                                            4095, 4095, 4095));
    pending_requests.push_back(make_request(REQ_SENSE, 0, 0, DIR_N, MAP_SEEN, 2049, 2048, 0));
    pending_requests.push_back(make_request(REQ_SENSE, 15, 15, DIR_E, MAP_UNUSED,
                                            4095, 4095, 4095));
    pending_requests.push_back(make_request(REQ_SENSE, 7, 8, DIR_W, MAP_SEEN, 0, 0, 0));
    pending_requests.push_back(make_request(REQ_SENSE, 3, 12, DIR_S, MAP_SEEN, 2047, 4095, 2049));
    pending_requests.push_back(make_request(REQ_QUERY, 0, 0, DIR_N, MAP_SEEN, 0, 0, 0));
    pending_requests.push_back(make_request(REQ_QUERY, 7, 8, DIR_W, MAP_PESS, 0, 0, 0));
    pending_requests.push_back(make_request(REQ_QUERY, 7, 8, DIR_E, MAP_CHECKED, 0, 0, 0));
    pending_requests.push_back(make_request(REQ_QUERY, 15, 15, DIR_N, MAP_PESS, 0, 0, 0));
    pending_requests.push_back(make_request(REQ_QUERY, 3, 12, DIR_E, MAP_SEEN, 0, 0, 0));
    pending_requests.push_back(make_request(REQ_UNUSED, 15, 15, DIR_E, MAP_UNUSED,
                                            4095, 4095, 4095));
    pending_requests.push_back(make_request(REQ_REINIT, 0, 0, DIR_N, MAP_SEEN, 0, 0, 0));
    pending_requests.push_back(make_request(REQ_QUERY, 7, 8, DIR_W, MAP_PESS, 0, 0, 0));
    pending_requests.push_back(make_request(REQ_QUERY, 0, 0, DIR_N, MAP_SEEN, 0, 0, 0));
    pending_requests.push_back(make_request(REQ_QUERY, 7, 8, DIR_N, MAP_CHECKED, 0, 0, 0));
  endtask

  initial begin
    boot_walls();
    mapping_on  = 1'b1;
    front_limit = 12'd2048;
    right_limit = 12'd2048;
    left_limit  = 12'd2048;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) configure_phase(p);
      idle_on = (p % 3 != 1);
      if (p == 0) load_boot_checks();
      // With mapping off an update leaves the maps alone but still reports.
      if (p == 3) begin
        pending_requests.push_back(make_request(REQ_SENSE, 5, 5, DIR_N, MAP_SEEN, 0, 4095, 0));
        pending_requests.push_back(make_request(REQ_QUERY, 5, 5, DIR_N, MAP_PESS, 0, 0, 0));
        pending_requests.push_back(make_request(REQ_QUERY, 5, 5, DIR_W, MAP_CHECKED, 0, 0, 0));
      end
      repeat (ITEMS_PER_PHASE) pending_requests.push_back(draw_request());
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
